>>> sv/snfcs_pkg.sv
// Shared types, constants and result builders of the SPI NOR flash command sequencer.
package snfcs_pkg;

    localparam int PAGE_BYTES  = 256;
    localparam int PAGE_LG     = $clog2(PAGE_BYTES);
    localparam int CHUNK_W     = PAGE_LG + 1;
    localparam int ADDR_W      = 24;
    localparam int CNT_W       = 25;
    localparam int ID_W        = 24;
    localparam int MAX_RESULTS = 5;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [ID_W-1:0] ID_RESET = 24'hEF4015;

    // SPI NOR command bytes
    localparam logic [7:0] CMD_PAGE_PROG  = 8'h02;
    localparam logic [7:0] CMD_FAST_READ  = 8'h0B;
    localparam logic [7:0] CMD_WREN       = 8'h06;
    localparam logic [7:0] CMD_READ_SR    = 8'h05;
    localparam logic [7:0] CMD_BLK_ERASE  = 8'hD8;
    localparam logic [7:0] CMD_CHIP_ERASE = 8'hC7;
    localparam logic [7:0] CMD_JEDEC_ID   = 8'h9F;
    localparam logic [7:0] CMD_PWR_DOWN   = 8'hB9;
    localparam logic [7:0] DUMMY_BYTE     = 8'h00;

    typedef enum logic [3:0] {
        OP_WR_BEGIN        = 4'd0,
        OP_WR_BYTE         = 4'd1,
        OP_REPLY           = 4'd2,
        OP_RD_BEGIN        = 4'd3,
        OP_RD_BYTE         = 4'd4,
        OP_RD_END          = 4'd5,
        OP_ERASE_64K       = 4'd6,
        OP_CHIP_ERASE      = 4'd7,
        OP_CHIP_ERASE_WAIT = 4'd8,
        OP_CHECK_ID        = 4'd9,
        OP_POWER_DOWN      = 4'd10,
        OP_STATUS          = 4'd11
    } t_opcode;

    typedef enum logic [2:0] {
        RPT_NONE        = 3'd0,
        RPT_DONE        = 3'd1,
        RPT_ID_MATCH    = 3'd2,
        RPT_ID_MISMATCH = 3'd3,
        RPT_PROTO_ERR   = 3'd4
    } t_report;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WR_DATA,
        MODE_WR_POLL,
        MODE_RD_OPEN,
        MODE_RD_WAIT,
        MODE_CE_POLL,
        MODE_ID_WAIT,
        MODE_ST_WAIT
    } t_mode;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [ADDR_W-1:0] flash_address;
        logic [CNT_W-1:0]  byte_count;
        logic [7:0]        data_byte;
    } t_req;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_start;
        logic       frame_end;
        logic       wants_reply;
        logic       host_valid;
        logic [7:0] host_byte;
        t_report    report;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]           count;
        t_result [MAX_RESULTS-1:0]      res;
    } t_batch;

    localparam t_result RES_EMPTY = '0;

    // One SPI byte exchange
    function automatic t_result xfer(input logic [7:0] b, input logic fs, input logic fe,
                                     input logic wr, input t_report rep);
        t_result r;
        r             = RES_EMPTY;
        r.tx_valid    = 1'b1;
        r.tx_byte     = b;
        r.frame_start = fs;
        r.frame_end   = fe;
        r.wants_reply = wr;
        r.report      = rep;
        return r;
    endfunction

    // Byte handed back to the host
    function automatic t_result host(input logic [7:0] b);
        t_result r;
        r            = RES_EMPTY;
        r.host_valid = 1'b1;
        r.host_byte  = b;
        return r;
    endfunction

    // Report with no exchange
    function automatic t_result note(input logic fe, input t_report rep);
        t_result r;
        r           = RES_EMPTY;
        r.frame_end = fe;
        r.report    = rep;
        return r;
    endfunction

endpackage

>>> sv/snfcs_if.sv
// Request, response and configuration channel interfaces.
interface snfcs_req_if;
    logic                         valid;
    logic                         ready;
    logic [3:0]                   opcode;
    logic [snfcs_pkg::ADDR_W-1:0] flash_address;
    logic [snfcs_pkg::CNT_W-1:0]  byte_count;
    logic [7:0]                   data_byte;

    modport source (output valid, opcode, flash_address, byte_count, data_byte, input ready);
    modport sink   (input valid, opcode, flash_address, byte_count, data_byte, output ready);
endinterface

interface snfcs_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       wants_reply;
    logic       host_valid;
    logic [7:0] host_byte;
    logic [2:0] report;
    logic       last;

    modport source (output valid, tx_valid, tx_byte, frame_start, frame_end, wants_reply,
                    host_valid, host_byte, report, last, input ready);
    modport sink   (input valid, tx_valid, tx_byte, frame_start, frame_end, wants_reply,
                    host_valid, host_byte, report, last, output ready);
endinterface

interface snfcs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [snfcs_pkg::ID_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/snfcs_in_reg.sv
// Input register that holds one accepted request until the decoder takes it.
module snfcs_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    snfcs_req_if.sink       i_req,
    input  logic            i_take,
    output logic            o_valid,
    output snfcs_pkg::t_req o_item
);
    import snfcs_pkg::*;

    logic r_valid;
    t_req r_item;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.opcode        <= i_req.opcode;
            r_item.flash_address <= i_req.flash_address;
            r_item.byte_count    <= i_req.byte_count;
            r_item.data_byte     <= i_req.data_byte;
        end
    end

endmodule

>>> sv/snfcs_decode.sv
// Sequencer state and combinational request decode into a batch of results.
module snfcs_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    snfcs_cfg_if.sink         i_cfg,
    input  logic              i_item_valid,
    input  snfcs_pkg::t_req   i_item,
    input  logic              i_load_ready,
    output logic              o_take,
    output snfcs_pkg::t_batch o_batch
);
    import snfcs_pkg::*;

    t_mode               r_mode, n_mode;
    logic [ADDR_W-1:0]   r_cur_addr, n_cur_addr;
    logic [CNT_W-1:0]    r_bytes_rem, n_bytes_rem;
    logic [CHUNK_W-1:0]  r_chunk_rem, n_chunk_rem;
    logic [1:0]          r_id_idx, n_id_idx;
    logic                r_id_mism, n_id_mism;
    logic [ID_W-1:0]     r_expected_id;

    logic [ADDR_W-1:0]   chunk_addr;
    logic [CNT_W-1:0]    chunk_total;
    logic [CNT_W-1:0]    room;
    logic [CNT_W-1:0]    chunk_len;
    logic [7:0]          id_byte;
    logic                id_mism;
    logic                bad;
    t_batch              n_batch;

    assign i_cfg.ready = 1'b1;
    assign o_take      = i_item_valid && i_load_ready;
    assign o_batch     = n_batch;

    // Write enable, page program and the three address bytes of one page chunk
    function automatic t_batch chunk_batch(input logic [ADDR_W-1:0] a);
        t_batch b;
        b        = '0;
        b.count  = RES_CNT_W'(5);
        b.res[0] = xfer(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
        b.res[1] = xfer(CMD_PAGE_PROG, 1'b1, 1'b0, 1'b0, RPT_NONE);
        b.res[2] = xfer(a[23:16], 1'b0, 1'b0, 1'b0, RPT_NONE);
        b.res[3] = xfer(a[15:8], 1'b0, 1'b0, 1'b0, RPT_NONE);
        b.res[4] = xfer(a[7:0], 1'b0, 1'b0, 1'b0, RPT_NONE);
        return b;
    endfunction

    // Chunk length: bytes left, cut at the next page boundary
    always_comb begin
        if (i_item.opcode == OP_WR_BEGIN) begin
            chunk_addr  = i_item.flash_address;
            chunk_total = i_item.byte_count;
        end else begin
            chunk_addr  = r_cur_addr;
            chunk_total = r_bytes_rem;
        end
        room      = CNT_W'(PAGE_BYTES) - CNT_W'(chunk_addr[PAGE_LG-1:0]);
        chunk_len = (chunk_total < room) ? chunk_total : room;
    end

    always_comb begin
        case (r_id_idx)
            2'd0:    id_byte = r_expected_id[23:16];
            2'd1:    id_byte = r_expected_id[15:8];
            default: id_byte = r_expected_id[7:0];
        endcase
        id_mism = r_id_mism || (id_byte != i_item.data_byte);
    end

    always_comb begin
        n_mode      = r_mode;
        n_cur_addr  = r_cur_addr;
        n_bytes_rem = r_bytes_rem;
        n_chunk_rem = r_chunk_rem;
        n_id_idx    = r_id_idx;
        n_id_mism   = r_id_mism;
        n_batch     = '0;
        bad         = 1'b0;

        unique case (i_item.opcode) inside
            OP_WR_BEGIN: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else if (i_item.byte_count == '0) begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = note(1'b0, RPT_DONE);
                end else begin
                    n_cur_addr  = i_item.flash_address;
                    n_bytes_rem = i_item.byte_count;
                    n_chunk_rem = chunk_len[CHUNK_W-1:0];
                    n_batch     = chunk_batch(i_item.flash_address);
                    n_mode      = MODE_WR_DATA;
                end
            end
            OP_WR_BYTE: begin
                if (r_mode != MODE_WR_DATA || r_chunk_rem == '0) begin
                    bad = 1'b1;
                end else begin
                    n_chunk_rem = r_chunk_rem - CHUNK_W'(1);
                    n_bytes_rem = r_bytes_rem - CNT_W'(1);
                    n_cur_addr  = r_cur_addr + ADDR_W'(1);
                    if (r_chunk_rem != CHUNK_W'(1)) begin
                        n_batch.count  = RES_CNT_W'(1);
                        n_batch.res[0] = xfer(i_item.data_byte, 1'b0, 1'b0, 1'b0, RPT_NONE);
                    end else begin
                        // last byte of the page: close the frame and start polling
                        n_batch.count  = RES_CNT_W'(3);
                        n_batch.res[0] = xfer(i_item.data_byte, 1'b0, 1'b1, 1'b0, RPT_NONE);
                        n_batch.res[1] = xfer(CMD_READ_SR, 1'b1, 1'b0, 1'b0, RPT_NONE);
                        n_batch.res[2] = xfer(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                        n_mode         = MODE_WR_POLL;
                    end
                end
            end
            OP_REPLY: begin
                if (r_mode == MODE_WR_POLL || r_mode == MODE_CE_POLL) begin
                    if (i_item.data_byte[0]) begin
                        n_batch.count  = RES_CNT_W'(2);
                        n_batch.res[0] = xfer(CMD_READ_SR, 1'b1, 1'b0, 1'b0, RPT_NONE);
                        n_batch.res[1] = xfer(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                    end else if (r_mode == MODE_CE_POLL || r_bytes_rem == '0) begin
                        n_batch.count  = RES_CNT_W'(1);
                        n_batch.res[0] = note(1'b0, RPT_DONE);
                        n_mode         = MODE_IDLE;
                    end else begin
                        n_chunk_rem = chunk_len[CHUNK_W-1:0];
                        n_batch     = chunk_batch(r_cur_addr);
                        n_mode      = MODE_WR_DATA;
                    end
                end else if (r_mode == MODE_RD_WAIT) begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = host(i_item.data_byte);
                    n_mode         = MODE_RD_OPEN;
                end else if (r_mode == MODE_ST_WAIT) begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = host(i_item.data_byte);
                    n_mode         = MODE_IDLE;
                end else if (r_mode == MODE_ID_WAIT) begin
                    n_id_mism = id_mism;
                    if (r_id_idx >= 2'd2) begin
                        n_batch.count  = RES_CNT_W'(1);
                        n_batch.res[0] = note(1'b0, id_mism ? RPT_ID_MISMATCH : RPT_ID_MATCH);
                        n_id_idx       = 2'd0;
                        n_mode         = MODE_IDLE;
                    end else begin
                        n_id_idx = r_id_idx + 2'd1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            OP_RD_BEGIN: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(5);
                    n_batch.res[0] = xfer(CMD_FAST_READ, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    n_batch.res[1] = xfer(i_item.flash_address[23:16], 1'b0, 1'b0, 1'b0,
                                          RPT_NONE);
                    n_batch.res[2] = xfer(i_item.flash_address[15:8], 1'b0, 1'b0, 1'b0,
                                          RPT_NONE);
                    n_batch.res[3] = xfer(i_item.flash_address[7:0], 1'b0, 1'b0, 1'b0,
                                          RPT_NONE);
                    n_batch.res[4] = xfer(DUMMY_BYTE, 1'b0, 1'b0, 1'b0, RPT_NONE);
                    n_mode         = MODE_RD_OPEN;
                end
            end
            OP_RD_BYTE: begin
                if (r_mode != MODE_RD_OPEN) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = xfer(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    n_mode         = MODE_RD_WAIT;
                end
            end
            OP_RD_END: begin
                if (r_mode != MODE_RD_OPEN) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = note(1'b1, RPT_DONE);
                    n_mode         = MODE_IDLE;
                end
            end
            OP_ERASE_64K: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(5);
                    n_batch.res[0] = xfer(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
                    n_batch.res[1] = xfer(CMD_BLK_ERASE, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    n_batch.res[2] = xfer(i_item.flash_address[23:16], 1'b0, 1'b0, 1'b0,
                                          RPT_NONE);
                    n_batch.res[3] = xfer(i_item.flash_address[15:8], 1'b0, 1'b0, 1'b0,
                                          RPT_NONE);
                    n_batch.res[4] = xfer(i_item.flash_address[7:0], 1'b0, 1'b1, 1'b0,
                                          RPT_DONE);
                end
            end
            OP_CHIP_ERASE, OP_CHIP_ERASE_WAIT: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.res[0] = xfer(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
                    if (i_item.opcode == OP_CHIP_ERASE) begin
                        n_batch.count  = RES_CNT_W'(2);
                        n_batch.res[1] = xfer(CMD_CHIP_ERASE, 1'b1, 1'b1, 1'b0, RPT_DONE);
                    end else begin
                        n_batch.count  = RES_CNT_W'(4);
                        n_batch.res[1] = xfer(CMD_CHIP_ERASE, 1'b1, 1'b1, 1'b0, RPT_NONE);
                        n_batch.res[2] = xfer(CMD_READ_SR, 1'b1, 1'b0, 1'b0, RPT_NONE);
                        n_batch.res[3] = xfer(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                        n_mode         = MODE_CE_POLL;
                    end
                end
            end
            OP_CHECK_ID: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(4);
                    n_batch.res[0] = xfer(CMD_JEDEC_ID, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    n_batch.res[1] = xfer(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    n_batch.res[2] = xfer(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    n_batch.res[3] = xfer(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                    n_id_idx       = 2'd0;
                    n_id_mism      = 1'b0;
                    n_mode         = MODE_ID_WAIT;
                end
            end
            OP_POWER_DOWN: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(1);
                    n_batch.res[0] = xfer(CMD_PWR_DOWN, 1'b1, 1'b1, 1'b0, RPT_DONE);
                end
            end
            OP_STATUS: begin
                if (r_mode != MODE_IDLE) begin
                    bad = 1'b1;
                end else begin
                    n_batch.count  = RES_CNT_W'(2);
                    n_batch.res[0] = xfer(CMD_READ_SR, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    n_batch.res[1] = xfer(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                    n_mode         = MODE_ST_WAIT;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        // misplaced or unknown opcode: state already held, report only
        if (bad) begin
            n_batch        = '0;
            n_batch.count  = RES_CNT_W'(1);
            n_batch.res[0] = note(1'b0, RPT_PROTO_ERR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_cur_addr  <= '0;
            r_bytes_rem <= '0;
            r_chunk_rem <= '0;
            r_id_idx    <= '0;
            r_id_mism   <= 1'b0;
        end else if (o_take) begin
            r_mode      <= n_mode;
            r_cur_addr  <= n_cur_addr;
            r_bytes_rem <= n_bytes_rem;
            r_chunk_rem <= n_chunk_rem;
            r_id_idx    <= n_id_idx;
            r_id_mism   <= n_id_mism;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= ID_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_expected_id <= i_cfg.data;
        end
    end

    a_id_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_ID_WAIT |-> r_id_idx == 2'd0)
        else $error("ID byte index left nonzero outside ID wait");

    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_WR_DATA |-> r_chunk_rem != '0)
        else $error("write data mode with empty chunk");

    a_batch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> n_batch.count <= RES_CNT_W'(MAX_RESULTS))
        else $error("batch exceeds result capacity");

endmodule

>>> sv/snfcs_emit.sv
// Result register that holds one batch and hands its results out one per cycle while the receiver is ready.
module snfcs_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  snfcs_pkg::t_batch i_batch,
    output logic              o_load_ready,
    snfcs_rsp_if.source       o_rsp
);
    import snfcs_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_batch           r_batch;
    t_result          cur;
    logic             at_last;
    logic             fire;

    assign cur     = r_batch.res[r_idx];
    assign at_last = (RES_CNT_W'(r_idx) + RES_CNT_W'(1)) == r_batch.count;
    assign fire    = r_busy && o_rsp.ready;

    assign o_load_ready = !r_busy || (fire && at_last);

    assign o_rsp.valid       = r_busy;
    assign o_rsp.tx_valid    = cur.tx_valid;
    assign o_rsp.tx_byte     = cur.tx_byte;
    assign o_rsp.frame_start = cur.frame_start;
    assign o_rsp.frame_end   = cur.frame_end;
    assign o_rsp.wants_reply = cur.wants_reply;
    assign o_rsp.host_valid  = cur.host_valid;
    assign o_rsp.host_byte   = cur.host_byte;
    assign o_rsp.report      = cur.report;
    assign o_rsp.last        = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= (i_batch.count != '0);
            r_idx  <= '0;
        end else if (fire) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
    end

    a_idx_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> RES_CNT_W'(r_idx) < r_batch.count)
        else $error("result index beyond batch");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_batch.count != '0) |=> (r_busy && r_idx == '0))
        else $error("loaded batch not started at first result");

endmodule

>>> sv/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer.
// Path: an accepted request is held in the input register, decoded combinationally,
//   and its batch loaded into the result register once that register can take it.
// Results: a request's results (up to 5) leave the result register one per cycle while
//   the receiver is ready; the next batch loads as the last result leaves.
// Reset: synchronous, active low; mode returns to idle, counters clear, the expected
//   device ID returns to 0xEF4015. No clearing pass follows reset.
module spi_nor_flash_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snfcs_req_if.sink   i_req,
    snfcs_rsp_if.source o_rsp,
    snfcs_cfg_if.sink   i_cfg
);
    import snfcs_pkg::*;

    logic   item_valid;
    t_req   item;
    logic   take;
    logic   load_ready;
    t_batch batch;

    // Hold the accepted request; release it once the decoder takes it.
    snfcs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // Decode the request against the sequencer mode, advance state and build
    // the whole batch of exchanges and reports combinationally.
    snfcs_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_load_ready (load_ready),
        .o_take       (take),
        .o_batch      (batch)
    );

    // Drain the batch one result per cycle while the receiver is ready; accept the
    // next batch on the cycle the last result leaves, so the pipe never stalls on its own.
    snfcs_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take),
        .i_batch      (batch),
        .o_load_ready (load_ready),
        .o_rsp        (o_rsp)
    );

endmodule

>>> tb/spi_nor_flash_command_sequencer_tb.sv
// Self-checking testbench for the SPI NOR flash command sequencer.
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_tb;
    import snfcs_pkg::*;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          RANDOM_GOAL    = 28;
    localparam logic [3:0]  OP_UNUSED_LAST = 4'd15;

    // One expected result beat: the package result plus the end-of-request flag
    typedef struct packed {
        t_result    res;
        logic       last;
    } t_spi_result;

    logic clk;
    logic rst_n;

    snfcs_req_if req_if ();
    snfcs_rsp_if rsp_if ();
    snfcs_cfg_if cfg_if ();

    spi_nor_flash_command_sequencer DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Request stream and expected results
    t_req          pending_reqs[$];
    t_spi_result   queued_exchanges[$];
    t_spi_result   step_out[$];
    int unsigned   requests_planned;
    int unsigned   requests_taken;
    int unsigned   results_seen;
    int unsigned   proto_errors;
    int unsigned   mismatches;
    int unsigned   id_settings;
    int unsigned   cycle_count;
    logic          noise_on;
    logic [ID_W-1:0] planned_id;

    // Sequencer state as the checker sees it
    t_mode              flash_mode;
    logic [ADDR_W-1:0]  prog_addr;
    logic [CNT_W-1:0]   prog_left;
    logic [CHUNK_W-1:0] page_left;
    logic [1:0]         id_pos;
    logic               id_differs;
    logic [ID_W-1:0]    dev_id;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Expected SPI exchanges and host reports
    // ------------------------------------------------------------------
    function automatic void emit(input logic txv, input logic [7:0] b, input logic fs,
                                 input logic fe, input logic wr, input logic hv,
                                 input logic [7:0] hb, input t_report rep);
        t_spi_result e;
        e.res.tx_valid    = txv;
        e.res.tx_byte     = txv ? b : 8'h00;
        e.res.frame_start = fs;
        e.res.frame_end   = fe;
        e.res.wants_reply = wr;
        e.res.host_valid  = hv;
        e.res.host_byte   = hv ? hb : 8'h00;
        e.res.report      = rep;
        e.last            = 1'b0;
        step_out.push_back(e);
    endfunction

    function automatic void emit_tx(input logic [7:0] b, input logic fs, input logic fe,
                                    input logic wr, input t_report rep);
        emit(1'b1, b, fs, fe, wr, 1'b0, 8'h00, rep);
    endfunction

    // Send the three address bytes, high byte first
    function automatic void emit_address(input logic [ADDR_W-1:0] a, input logic fe);
        emit_tx(a[23:16], 1'b0, 1'b0, 1'b0, RPT_NONE);
        emit_tx(a[15:8], 1'b0, 1'b0, 1'b0, RPT_NONE);
        emit_tx(a[7:0], 1'b0, fe, 1'b0, fe ? RPT_DONE : RPT_NONE);
    endfunction

    function automatic void emit_status_poll();
        emit_tx(CMD_READ_SR, 1'b1, 1'b0, 1'b0, RPT_NONE);
        emit_tx(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
    endfunction

    // Open a page program up to the next page boundary
    function automatic void open_page_program();
        int unsigned room;
        room = PAGE_BYTES - prog_addr[PAGE_LG-1:0];
        page_left = (prog_left < room) ? CHUNK_W'(prog_left) : CHUNK_W'(room);
        emit_tx(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
        emit_tx(CMD_PAGE_PROG, 1'b1, 1'b0, 1'b0, RPT_NONE);
        emit_address(prog_addr, 1'b0);
        flash_mode = MODE_WR_DATA;
    endfunction

    function automatic void sequence_request(input t_req r);
        logic       fault;
        logic [7:0] id_byte;
        fault = 1'b0;
        step_out.delete();
        case (r.opcode)
            OP_WR_BEGIN: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else if (r.byte_count == '0) begin
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, RPT_DONE);
                end else begin
                    prog_addr = r.flash_address;
                    prog_left = r.byte_count;
                    open_page_program();
                end
            end
            OP_WR_BYTE: begin
                if (flash_mode != MODE_WR_DATA || page_left == '0) begin
                    fault = 1'b1;
                end else begin
                    page_left--;
                    prog_left--;
                    prog_addr++;
                    if (page_left != '0) begin
                        emit_tx(r.data_byte, 1'b0, 1'b0, 1'b0, RPT_NONE);
                    end else begin
                        emit_tx(r.data_byte, 1'b0, 1'b1, 1'b0, RPT_NONE);
                        emit_status_poll();
                        flash_mode = MODE_WR_POLL;
                    end
                end
            end
            OP_REPLY: begin
                if (flash_mode == MODE_WR_POLL || flash_mode == MODE_CE_POLL) begin
                    if (r.data_byte[0]) begin
                        emit_status_poll();
                    end else if (flash_mode == MODE_CE_POLL || prog_left == '0) begin
                        emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, RPT_DONE);
                        flash_mode = MODE_IDLE;
                    end else begin
                        open_page_program();
                    end
                end else if (flash_mode == MODE_RD_WAIT) begin
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, r.data_byte, RPT_NONE);
                    flash_mode = MODE_RD_OPEN;
                end else if (flash_mode == MODE_ST_WAIT) begin
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, r.data_byte, RPT_NONE);
                    flash_mode = MODE_IDLE;
                end else if (flash_mode == MODE_ID_WAIT) begin
                    id_byte = 8'(dev_id >> (16 - 8 * id_pos));
                    if (id_byte != r.data_byte) id_differs = 1'b1;
                    if (id_pos >= 2'd2) begin
                        emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,
                             id_differs ? RPT_ID_MISMATCH : RPT_ID_MATCH);
                        id_pos     = 2'd0;
                        flash_mode = MODE_IDLE;
                    end else begin
                        id_pos++;
                    end
                end else begin
                    fault = 1'b1;
                end
            end
            OP_RD_BEGIN: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else begin
                    emit_tx(CMD_FAST_READ, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    emit_address(r.flash_address, 1'b0);
                    emit_tx(DUMMY_BYTE, 1'b0, 1'b0, 1'b0, RPT_NONE);
                    flash_mode = MODE_RD_OPEN;
                end
            end
            OP_RD_BYTE: begin
                if (flash_mode != MODE_RD_OPEN) begin
                    fault = 1'b1;
                end else begin
                    emit_tx(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    flash_mode = MODE_RD_WAIT;
                end
            end
            OP_RD_END: begin
                if (flash_mode != MODE_RD_OPEN) begin
                    fault = 1'b1;
                end else begin
                    emit(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, RPT_DONE);
                    flash_mode = MODE_IDLE;
                end
            end
            OP_ERASE_64K: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else begin
                    emit_tx(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
                    emit_tx(CMD_BLK_ERASE, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    emit_address(r.flash_address, 1'b1);
                end
            end
            OP_CHIP_ERASE, OP_CHIP_ERASE_WAIT: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else begin
                    emit_tx(CMD_WREN, 1'b1, 1'b1, 1'b0, RPT_NONE);
                    emit_tx(CMD_CHIP_ERASE, 1'b1, 1'b1, 1'b0,
                            (r.opcode == OP_CHIP_ERASE) ? RPT_DONE : RPT_NONE);
                    if (r.opcode == OP_CHIP_ERASE_WAIT) begin
                        emit_status_poll();
                        flash_mode = MODE_CE_POLL;
                    end
                end
            end
            OP_CHECK_ID: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else begin
                    emit_tx(CMD_JEDEC_ID, 1'b1, 1'b0, 1'b0, RPT_NONE);
                    emit_tx(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    emit_tx(DUMMY_BYTE, 1'b0, 1'b0, 1'b1, RPT_NONE);
                    emit_tx(DUMMY_BYTE, 1'b0, 1'b1, 1'b1, RPT_NONE);
                    id_pos     = 2'd0;
                    id_differs = 1'b0;
                    flash_mode = MODE_ID_WAIT;
                end
            end
            OP_POWER_DOWN: begin
                if (flash_mode != MODE_IDLE) fault = 1'b1;
                else emit_tx(CMD_PWR_DOWN, 1'b1, 1'b1, 1'b0, RPT_DONE);
            end
            OP_STATUS: begin
                if (flash_mode != MODE_IDLE) begin
                    fault = 1'b1;
                end else begin
                    emit_status_poll();
                    flash_mode = MODE_ST_WAIT;
                end
            end
            default: fault = 1'b1;
        endcase

        // A rejected request leaves the state alone and gives a single error report
        if (fault) begin
            step_out.delete();
            emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, RPT_PROTO_ERR);
            proto_errors++;
        end
        if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) queued_exchanges.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Request planning
    // ------------------------------------------------------------------
    function automatic t_req any_req(input logic [3:0] op);
        t_req r;
        r.opcode        = op;
        r.flash_address = ADDR_W'($urandom);
        r.byte_count    = CNT_W'($urandom);
        r.data_byte     = 8'($urandom);
        return r;
    endfunction

    function automatic void add(input t_req r);
        pending_reqs.push_back(r);
        requests_planned++;
    endfunction

    function automatic logic opcode_fits(input t_mode m, input logic [3:0] op);
        case (m)
            MODE_IDLE:    return op inside {OP_WR_BEGIN, OP_RD_BEGIN, OP_ERASE_64K,
                                            OP_CHIP_ERASE, OP_CHIP_ERASE_WAIT, OP_CHECK_ID,
                                            OP_POWER_DOWN, OP_STATUS};
            MODE_WR_DATA: return op == OP_WR_BYTE;
            MODE_RD_OPEN: return op == OP_RD_BYTE || op == OP_RD_END;
            default:      return op == OP_REPLY;
        endcase
    endfunction

    // Draw a request the block must reject in mode m
    function automatic t_req misplaced(input t_mode m);
        t_req r;
        do r = any_req(4'($urandom_range(0, 15))); while (opcode_fits(m, r.opcode));
        return r;
    endfunction

    function automatic void maybe_noise(input t_mode m);
        if (noise_on && $urandom_range(0, 11) == 0) add(misplaced(m));
    endfunction

    // Busy replies with bit 0 set, then one that clears it
    function automatic void plan_busy_wait(input t_mode m);
        t_req r;
        repeat ($urandom_range(0, 2)) begin
            maybe_noise(m);
            r = any_req(OP_REPLY);
            r.data_byte[0] = 1'b1;
            add(r);
        end
        maybe_noise(m);
        r = any_req(OP_REPLY);
        r.data_byte[0] = 1'b0;
        add(r);
    endfunction

    function automatic void plan_write(input logic [ADDR_W-1:0] a, input int unsigned n);
        t_req        r;
        int unsigned room;
        int unsigned part;
        r = any_req(OP_WR_BEGIN);
        r.flash_address = a;
        r.byte_count    = CNT_W'(n);
        add(r);
        while (n != 0) begin
            room = PAGE_BYTES - a[PAGE_LG-1:0];
            part = (n < room) ? n : room;
            n   -= part;
            a   += ADDR_W'(part);
            repeat (part) begin
                maybe_noise(MODE_WR_DATA);
                add(any_req(OP_WR_BYTE));
            end
            plan_busy_wait(MODE_WR_POLL);
        end
    endfunction

    function automatic void plan_read(input logic [ADDR_W-1:0] a, input int unsigned n);
        t_req r;
        r = any_req(OP_RD_BEGIN);
        r.flash_address = a;
        add(r);
        repeat (n) begin
            maybe_noise(MODE_RD_OPEN);
            add(any_req(OP_RD_BYTE));
            maybe_noise(MODE_RD_WAIT);
            add(any_req(OP_REPLY));
        end
        maybe_noise(MODE_RD_OPEN);
        add(any_req(OP_RD_END));
    endfunction

    // Reply with the configured ID, or spoil one of its bytes
    function automatic void plan_check_id(input logic match);
        t_req r;
        int   spoil;
        spoil = match ? 3 : $urandom_range(0, 2);
        add(any_req(OP_CHECK_ID));
        for (int i = 0; i < 3; i++) begin
            maybe_noise(MODE_ID_WAIT);
            r = any_req(OP_REPLY);
            r.data_byte = planned_id[23 - 8 * i -: 8];
            if (i == spoil) r.data_byte ^= 8'($urandom_range(1, 255));
            add(r);
        end
    endfunction

    function automatic void plan_status();
        add(any_req(OP_STATUS));
        maybe_noise(MODE_ST_WAIT);
        add(any_req(OP_REPLY));
    endfunction

    function automatic void plan_directed();
        t_req r;
        noise_on = 1'b0;
        // empty write at the top of the address space
        r = any_req(OP_WR_BEGIN);
        r.flash_address = {ADDR_W{1'b1}};
        r.byte_count    = '0;
        add(r);
        add(any_req(OP_UNUSED_LAST));
        add(any_req(OP_REPLY));
        add(any_req(OP_POWER_DOWN));
        plan_status();
        r = any_req(OP_ERASE_64K);
        r.flash_address = {ADDR_W{1'b1}};
        add(r);
        add(any_req(OP_CHIP_ERASE));
        plan_check_id(1'b1);
        // crosses a page boundary and wraps the address
        plan_write({ADDR_W{1'b1}} - 1, 3);
        // read with a misplaced write, only the top count bit set, in the middle
        r = any_req(OP_RD_BEGIN);
        r.flash_address = '0;
        add(r);
        add(any_req(OP_RD_BYTE));
        add(any_req(OP_REPLY));
        r = any_req(OP_WR_BEGIN);
        r.byte_count = {1'b1, 24'h0};
        add(r);
        add(any_req(OP_RD_END));
        add(any_req(OP_CHIP_ERASE_WAIT));
        plan_busy_wait(MODE_CE_POLL);
        noise_on = 1'b1;
    endfunction

    function automatic void plan_random_phase(input int unsigned goal);
        int unsigned       stop;
        logic [ADDR_W-1:0] a;
        t_req              r;
        stop = requests_planned + goal;
        while (requests_planned < stop) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    a = ADDR_W'($urandom);
                    if ($urandom_range(0, 1) == 1)
                        a[PAGE_LG-1:0] = PAGE_LG'(PAGE_BYTES - $urandom_range(1, 4));
                    if ($urandom_range(0, 15) == 0)
                        a = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 3));
                    plan_write(a, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                               : $urandom_range(0, 6));
                end
                3, 4: plan_read(ADDR_W'($urandom), $urandom_range(0, 4));
                5: add(any_req(OP_ERASE_64K));
                6: add(any_req(OP_CHIP_ERASE));
                7: begin
                    add(any_req(OP_CHIP_ERASE_WAIT));
                    plan_busy_wait(MODE_CE_POLL);
                end
                8: plan_check_id($urandom_range(0, 1) == 1);
                9: add(any_req(OP_POWER_DOWN));
                10: plan_status();
                default: add(misplaced(MODE_IDLE));
            endcase
        end
    endfunction

    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    t_req        driven_req;
    int unsigned req_wait;
    int unsigned req_calm;

    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_wait     <= 0;
            req_calm      = 0;
            flash_mode    = MODE_IDLE;
            prog_addr     = '0;
            prog_left     = '0;
            page_left     = '0;
            id_pos        = '0;
            id_differs    = 1'b0;
            dev_id        = ID_RESET;
        end else begin
            if (req_if.valid && req_if.ready) begin
                sequence_request(driven_req);
                requests_taken++;
            end
            // advance only once the current request is gone
            if (!req_if.valid || req_if.ready) begin
                if (req_wait != 0) begin
                    req_if.valid <= 1'b0;
                    req_wait     <= req_wait - 1;
                end else if (pending_reqs.size() != 0) begin
                    driven_req = pending_reqs.pop_front();
                    req_if.opcode        <= driven_req.opcode;
                    req_if.flash_address <= driven_req.flash_address;
                    req_if.byte_count    <= driven_req.byte_count;
                    req_if.data_byte     <= driven_req.data_byte;
                    req_if.valid         <= 1'b1;
                    req_wait             <= draw_gap(req_calm);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int unsigned rsp_wait;
    int unsigned rsp_calm;

    function automatic void compare_field(input string name, input logic [7:0] want_v,
                                          input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        t_spi_result want;
        int unsigned stall;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_wait     <= 0;
            rsp_calm      = 0;
        end else if (rsp_if.ready) begin
            if (rsp_if.valid) begin
                results_seen++;
                if (queued_exchanges.size() == 0) begin
                    $error("result arrived with no request waiting for it");
                    mismatches++;
                end else begin
                    want = queued_exchanges.pop_front();
                    compare_field("tx_valid", want.res.tx_valid, rsp_if.tx_valid);
                    compare_field("tx_byte", want.res.tx_byte, rsp_if.tx_byte);
                    compare_field("frame_start", want.res.frame_start, rsp_if.frame_start);
                    compare_field("frame_end", want.res.frame_end, rsp_if.frame_end);
                    compare_field("wants_reply", want.res.wants_reply, rsp_if.wants_reply);
                    compare_field("host_valid", want.res.host_valid, rsp_if.host_valid);
                    compare_field("host_byte", want.res.host_byte, rsp_if.host_byte);
                    compare_field("report", want.res.report, rsp_if.report);
                    compare_field("last", want.last, rsp_if.last);
                end
                // stall before the next result
                stall = draw_gap(rsp_calm);
                if (stall != 0) begin
                    rsp_if.ready <= 1'b0;
                    rsp_wait     <= stall - 1;
                end
            end
        end else if (rsp_wait != 0) begin
            rsp_wait <= rsp_wait - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence control
    // ------------------------------------------------------------------
    // Hold until every request is taken and every result is back, then let the
    // pipeline empty of requests that give no result
    task automatic settle(input int unsigned extra);
        while (requests_taken != requests_planned || queued_exchanges.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_device_id(input logic [ID_W-1:0] v);
        cfg_if.data  <= v;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        dev_id     = v;
        planned_id = v;
        id_settings++;
    endtask

    initial begin
        logic [ID_W-1:0] id_choices[4];
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.opcode        = '0;
        req_if.flash_address = '0;
        req_if.byte_count    = '0;
        req_if.data_byte     = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        requests_planned     = 0;
        requests_taken       = 0;
        results_seen         = 0;
        proto_errors         = 0;
        mismatches           = 0;
        cycle_count          = 0;
        id_settings          = 1;
        noise_on             = 1'b1;
        planned_id           = ID_RESET;
        id_choices           = '{24'h000000, 24'hFFFFFF, ID_W'($urandom), ID_RESET};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        plan_directed();
        settle(SETTLE_CYCLES);
        foreach (id_choices[i]) begin
            write_device_id(id_choices[i]);
            plan_random_phase(RANDOM_GOAL);
            settle(SETTLE_CYCLES);
        end
        settle(DRAIN_CYCLES);

        $display("Ran %0d requests (%0d rejected as misplaced) and checked %0d results",
                 requests_taken, proto_errors, results_seen);
        $display("under %0d expected device ID settings, with random stalls on both sides",
                 id_settings);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
